>>> src/sfe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the saturating feedback echo block.
package sfe_pkg;

  localparam int SAMPLE_W = 8;
  localparam int DELAY_W  = 12;
  localparam int GAIN_W   = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'hFF;
  localparam logic [DELAY_W-1:0]  DELAY_RST  = 12'd1;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd115;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_DELAY = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_idx_t;

  // One result item.
  typedef struct packed {
    logic                clipped;
    logic [SAMPLE_W-1:0] sample_out;
  } sfe_result_t;

endpackage

>>> src/sfe_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, tracks buffer position and works out echo use and addresses.
module sfe_front #(
  parameter int MAX_DELAY = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfe_pkg::SAMPLE_W-1:0]        sample_in,
  input  logic                                buffer_start,
  input  logic [sfe_pkg::DELAY_W-1:0]         delay_samples,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [sfe_pkg::SAMPLE_W-1:0]        push_sample,
  output logic                                push_echo,
  output logic [$clog2(MAX_DELAY)-1:0]        push_wp,
  output logic [$clog2(MAX_DELAY)-1:0]        push_rd
);
  import sfe_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int DW = (AW > DELAY_W) ? AW : DELAY_W;
  localparam logic [DW-1:0] DELAY_LIMIT = DW'(MAX_DELAY - 1);
  localparam logic [AW:0]   DEPTH       = (AW + 1)'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_ADDR   = AW'(MAX_DELAY - 1);

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW:0]   cnt_eff;
  logic [DW-1:0] delay_ext;
  logic [AW-1:0] d_eff;
  logic [AW:0]   rd_wide;
  logic          accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    delay_ext = DW'(delay_samples);
    // A delay beyond the store is clamped to the longest one it holds.
    if (delay_ext > DELAY_LIMIT) begin
      d_eff = DELAY_LIMIT[AW-1:0];
    end else begin
      d_eff = delay_ext[AW-1:0];
    end
    cnt_eff = buffer_start ? '0 : cnt_r;
    if ({1'b0, wp_r} >= {1'b0, d_eff}) begin
      rd_wide = {1'b0, wp_r} - {1'b0, d_eff};
    end else begin
      rd_wide = {1'b0, wp_r} + DEPTH - {1'b0, d_eff};
    end
    wp_nxt  = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
    cnt_nxt = (cnt_eff < DEPTH) ? cnt_eff + 1'b1 : cnt_eff;
  end

  assign push_sample = sample_in;
  assign push_echo   = (d_eff != '0) && (cnt_eff >= {1'b0, d_eff});
  assign push_wp     = wp_r;
  assign push_rd     = rd_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/sfe_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front and back parts.
module sfe_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import sfe_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         push;
  logic         pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/sfe_back.sv
`timescale 1ns / 1ps
// Back part: history memory, echo multiply-add with saturation, and the result register.
module sfe_back #(
  parameter int MAX_DELAY = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [sfe_pkg::SAMPLE_W-1:0]    q_sample,
  input  logic                            q_echo,
  input  logic [$clog2(MAX_DELAY)-1:0]    q_wp,
  input  logic [$clog2(MAX_DELAY)-1:0]    q_rd,
  input  logic [sfe_pkg::GAIN_W-1:0]      echo_gain,
  output logic                            res_valid,
  input  logic                            res_ready,
  output sfe_pkg::sfe_result_t            res
);
  import sfe_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);

  logic [SAMPLE_W-1:0] hist_mem [MAX_DELAY];

  logic                ex_valid_r;
  logic [SAMPLE_W-1:0] ex_sample_r;
  logic                ex_echo_r;
  logic [AW-1:0]       ex_wp_r;
  logic [SAMPLE_W-1:0] mem_q_r;
  logic                fwd_r;
  logic [SAMPLE_W-1:0] byp_r;
  logic                out_valid_r;
  sfe_result_t         out_res_r;

  logic [SAMPLE_W-1:0]        past;
  logic [SAMPLE_W+GAIN_W-1:0] prod;
  logic [SAMPLE_W:0]          sum;
  sfe_result_t                ex_res;
  logic                       out_free;
  logic                       ex_go;
  logic                       pop;

  assign out_free = !out_valid_r || res_ready;
  assign ex_go    = ex_valid_r && out_free;
  assign q_ready  = !ex_valid_r || out_free;
  assign pop      = q_valid && q_ready;

  always_comb begin
    // The previous output may have been written in the same cycle as this read.
    past = fwd_r ? byp_r : mem_q_r;
    prod = past * echo_gain;
    sum  = {1'b0, ex_sample_r} + {1'b0, prod[SAMPLE_W+GAIN_W-1:GAIN_W]};
    if (ex_echo_r) begin
      ex_res.clipped    = sum[SAMPLE_W];
      ex_res.sample_out = sum[SAMPLE_W] ? SAMPLE_MAX : sum[SAMPLE_W-1:0];
    end else begin
      ex_res.clipped    = 1'b0;
      ex_res.sample_out = ex_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go) begin
      hist_mem[ex_wp_r] <= ex_res.sample_out;
    end
    if (pop) begin
      mem_q_r <= hist_mem[q_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_ready) begin
        ex_valid_r <= q_valid;
      end
      if (pop) begin
        fwd_r <= ex_go && (q_rd == ex_wp_r);
      end
      if (out_free) begin
        out_valid_r <= ex_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex_sample_r <= q_sample;
      ex_echo_r   <= q_echo;
      ex_wp_r     <= q_wp;
      byp_r       <= ex_res.sample_out;
    end
    if (ex_go) begin
      out_res_r <= ex_res;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

endmodule

>>> src/saturating_feedback_echo.sv
`timescale 1ns / 1ps
// An accepted item passes through the queue, the execute register and the output register.
// Throughput: one item per cycle unless the output stalls, set by the feedback loop
// in the back part (history read, multiply by the gain, add, saturate, bypass to the
// next read). A two-entry queue and an output register let either side stall without
// a bubble. Reset (rst_n low, synchronous) empties the pipeline, restarts the buffer at
// address zero and loads delay 1 and gain 115; the history memory is not cleared.
module saturating_feedback_echo #(
  parameter int MAX_DELAY = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input items.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] sample_in
  input  logic                           in_tuser,   // [0] buffer_start
  // Result items.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] sample_out
  output logic                           out_tuser,  // [0] clipped
  // Configuration writes.
  input  logic                           cfg_wr_en,
  input  sfe_pkg::cfg_idx_t              cfg_addr,
  input  logic [sfe_pkg::DELAY_W-1:0]    cfg_wdata
);
  import sfe_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int QW = SAMPLE_W + 1 + 2 * AW;

  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  gain_r;

  // Configuration registers. User writes must come only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_DELAY: delay_r <= cfg_wdata;
        CFG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  // Front: one item is classified per cycle while the queue has room. It decides whether
  // the echo applies (enough outputs already produced in this buffer) and where to read and write.
  logic                push_valid;
  logic                push_ready;
  logic [SAMPLE_W-1:0] push_sample;
  logic                push_echo;
  logic [AW-1:0]       push_wp;
  logic [AW-1:0]       push_rd;

  sfe_front #(
    .MAX_DELAY (MAX_DELAY)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .sample_in     (in_tdata),
    .buffer_start  (in_tuser),
    .delay_samples (delay_r),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_sample   (push_sample),
    .push_echo     (push_echo),
    .push_wp       (push_wp),
    .push_rd       (push_rd)
  );

  // Queue between the two parts.
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  sfe_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_sample, push_echo, push_wp, push_rd}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: the history read is issued as an item leaves the queue; once the output register
  // is free, the item's result is computed, written back and loaded into the output register.
  sfe_result_t res;

  sfe_back #(
    .MAX_DELAY (MAX_DELAY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_sample  (pop_data[QW-1 -: SAMPLE_W]),
    .q_echo    (pop_data[2*AW]),
    .q_wp      (pop_data[2*AW-1 -: AW]),
    .q_rd      (pop_data[AW-1:0]),
    .echo_gain (gain_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = res.sample_out;
  assign out_tuser = res.clipped;

endmodule

>>> src/sfe_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the saturating feedback echo block, bound to its top level.
module sfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);
  import sfe_pkg::*;

  // Items accepted but not yet delivered.
  logic [2:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 3'd1;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A clipped result is always saturated.
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == SAMPLE_MAX)
    else $error("clipped result not saturated");

  // No result without an item in flight, and never more in flight than storage holds.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result without an accepted item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more items in flight than the pipeline holds");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind saturating_feedback_echo sfe_checker u_sfe_checker (.*);

>>> tb/sv/saturating_feedback_echo_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the saturating feedback echo block.
module saturating_feedback_echo_tb;
  import sfe_pkg::*;

  localparam int HIST_DEPTH = 4096;
  localparam int RAND_ITEMS = 950;
  localparam int LONG_ITEMS = 420;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_PRINTS = 100;

  // Kinds of rows in the directed stimulus.
  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // Receiver stall patterns.
  typedef enum logic [2:0] {
    RX_OPEN   = 3'd0,
    RX_COIN   = 3'd1,
    RX_SLOW   = 3'd2,
    RX_COMB   = 3'd3,
    RX_FREEZE = 3'd4
  } rx_mode_t;

  // One directed row. A configuration row writes both registers; an item row sends one
  // item and, where typed is set, carries the result that must come back for it.
  typedef struct packed {
    row_kind_t           kind;
    logic [DELAY_W-1:0]  delay;
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] sample;
    logic                start;
    logic                typed;
    logic [SAMPLE_W-1:0] exp_sample;
    logic                exp_clip;
  } stim_row_t;

  localparam int N_ROWS = 30;

  // Reset leaves delay 1 and gain 115. Rows marked typed are simple enough to work out by
  // hand; the others are left to the predictor.
  localparam stim_row_t STIM_ROWS [N_ROWS] = '{
    // Samples before any start marker form a buffer that began at reset.
    '{ROW_ITEM, 12'd0,    8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    // Full-scale sample on top of a full-scale echo saturates.
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
    // A start marker makes the sample pass through; the next one echoes it.
    '{ROW_ITEM, 12'd0,    8'd0,   8'd200, 1'b1, 1'b1, 8'd200, 1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd0,   1'b0, 1'b1, 8'd89,  1'b0},
    // Back-to-back start markers.
    '{ROW_ITEM, 12'd0,    8'd0,   8'd128, 1'b1, 1'b1, 8'd128, 1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd1,   1'b1, 1'b1, 8'd1,   1'b0},
    // Largest gain.
    '{ROW_CFG,  12'd1,    8'd255, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd0,   1'b0, 1'b1, 8'd254, 1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
    // Zero gain, within the same buffer.
    '{ROW_CFG,  12'd1,    8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd37,  1'b0, 1'b0, 8'd0,   1'b0},
    // Zero delay: every sample passes through without clipping.
    '{ROW_CFG,  12'd0,    8'd255, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    // A short delay that reaches past the pass-through samples.
    '{ROW_CFG,  12'd3,    8'd128, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd100, 1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd50,  1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    // Largest delay: the start of a buffer passes through.
    '{ROW_CFG,  12'd4095, 8'd255, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd9,   1'b1, 1'b1, 8'd9,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd250, 1'b0, 1'b1, 8'd250, 1'b0},
    // The delay shrinks within a buffer and takes effect on the next sample.
    '{ROW_CFG,  12'd2,    8'd200, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd100, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, 12'd0,    8'd0,   8'd200, 1'b0, 1'b0, 8'd0,   1'b0}
  };

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;   // [7:0] sample_in
  logic in_tuser;         // [0] buffer_start
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;  // [7:0] sample_out
  logic out_tuser;        // [0] clipped
  logic cfg_wr_en;
  cfg_idx_t cfg_addr;
  logic [DELAY_W-1:0] cfg_wdata;

  // Predictor state: a copy of the echo history and the registers as the block sees them.
  logic [SAMPLE_W-1:0] echo_hist [HIST_DEPTH];
  logic [DELAY_W-1:0] hist_wr_ptr;
  int buf_fill;
  logic [DELAY_W-1:0] shadow_delay;
  logic [GAIN_W-1:0] shadow_gain;

  // Results still owed by the block, oldest first.
  sfe_result_t echo_due [$];

  int fail_count;
  int idle_cycles;
  int burst_left;
  int rand_items;

  saturating_feedback_echo u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Works out the result of one sample and advances the predictor state. The output of
  // delay samples ago is read back only once that many outputs exist in the buffer. The
  // 12-bit pointer arithmetic wraps at the history depth on its own, and a 12-bit delay
  // never exceeds the deepest usable tap, so no clamp is needed.
  function automatic sfe_result_t echo_predict(input logic [SAMPLE_W-1:0] smp,
                                               input logic start);
    sfe_result_t res;
    logic [DELAY_W-1:0] rd_ptr;
    logic [15:0] prod;
    logic [8:0] sum;
    res.sample_out = smp;
    res.clipped = 1'b0;
    if (start) begin
      buf_fill = 0;
    end
    if (shadow_delay != '0 && buf_fill >= int'(shadow_delay)) begin
      rd_ptr = hist_wr_ptr - shadow_delay;
      prod = 16'(echo_hist[rd_ptr]) * 16'(shadow_gain);
      sum = {1'b0, smp} + {1'b0, prod[15:8]};
      if (sum[8]) begin
        res.sample_out = SAMPLE_MAX;
        res.clipped = 1'b1;
      end else begin
        res.sample_out = sum[7:0];
      end
    end
    echo_hist[hist_wr_ptr] = res.sample_out;
    hist_wr_ptr = hist_wr_ptr + 1'b1;
    if (buf_fill < HIST_DEPTH) begin
      buf_fill++;
    end
    return res;
  endfunction

  // Samples lean toward the extremes and toward loud values, so that clipping is common.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(180, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Waits until every owed result has come back. Starts and ends at a falling edge.
  task automatic wait_drained();
    while (echo_due.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Writes the delay, then the gain, on consecutive cycles. The upper bits of the data
  // word carry junk on the gain write, since the register keeps only its low byte.
  task automatic set_regs(input logic [DELAY_W-1:0] delay, input logic [GAIN_W-1:0] gain);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    shadow_delay = delay;
    @(negedge clk);
    cfg_addr <= CFG_GAIN;
    cfg_wdata <= {4'($urandom_range(0, 15)), gain};
    @(posedge clk);
    shadow_gain = gain;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one item in bursts: when a burst runs out, the sender either idles for a random
  // gap or, now and then, holds off until the block has drained, and then starts a new burst.
  // A gap of zero keeps tvalid high across the burst boundary.
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic start,
                           input logic typed, input sfe_result_t typed_res);
    int gap;
    sfe_result_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end else if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    res = echo_predict(smp, start);
    echo_due.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Result checker: each accepted result is compared field by field with the oldest
  // expectation.
  always @(posedge clk) begin
    sfe_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (echo_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
          $display("%0t: unexpected result item, expected none, got sample_out %0d clipped %0b",
                   $time, out_tdata, out_tuser);
        end
      end else begin
        exp_res = echo_due.pop_front();
        if (out_tdata !== exp_res.sample_out) begin
          fail_count++;
          if (fail_count <= MAX_PRINTS) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, exp_res.sample_out, out_tdata);
          end
        end
        if (out_tuser !== exp_res.clipped) begin
          fail_count++;
          if (fail_count <= MAX_PRINTS) begin
            $display("%0t: clipped mismatch, expected %0b, got %0b",
                     $time, exp_res.clipped, out_tuser);
          end
        end
      end
    end
  end

  // The receiver switches between stall patterns of random length, including spells of
  // steady readiness and short freezes.
  always @(negedge clk) begin
    static rx_mode_t rx_mode = RX_OPEN;
    static int mode_left = 0;
    static int comb_cnt = 0;
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 4));
      mode_left = (rx_mode == RX_FREEZE) ? $urandom_range(5, 40) : $urandom_range(32, 300);
    end
    mode_left--;
    comb_cnt++;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:   out_tready <= ($urandom_range(0, 5) == 0);
      RX_COMB:   out_tready <= (comb_cnt % 7 != 3) && (comb_cnt % 5 != 0);
      default:   out_tready <= 1'b0;
    endcase
  end

  // Watchdog: a long run of cycles with no item moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0] gain;
    int phase_len;
    int buf_left;
    logic start;
    sfe_result_t typed_res;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_DELAY;
    cfg_wdata = '0;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    rand_items = 0;
    hist_wr_ptr = '0;
    buf_fill = 0;
    shadow_delay = DELAY_RST;
    shadow_gain = GAIN_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    foreach (STIM_ROWS[i]) begin
      if (STIM_ROWS[i].kind == ROW_CFG) begin
        in_tvalid <= 1'b0;
        wait_drained();
        set_regs(STIM_ROWS[i].delay, STIM_ROWS[i].gain);
      end else begin
        typed_res.sample_out = STIM_ROWS[i].exp_sample;
        typed_res.clipped = STIM_ROWS[i].exp_clip;
        send_item(STIM_ROWS[i].sample, STIM_ROWS[i].start, STIM_ROWS[i].typed, typed_res);
      end
    end

    // Random part: phases of random settings, each a stream of buffers that open with a
    // start marker and run somewhat past the delay, with a stray start marker now and then.
    // Half of the phases carry on the buffer from before the register change.
    buf_left = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: delay = 12'd0;
        1: delay = 12'd1;
        2, 3, 4: delay = 12'($urandom_range(2, 8));
        5, 6, 7: delay = 12'($urandom_range(9, 64));
        8: delay = 12'($urandom_range(65, 400));
        default: delay = 12'($urandom_range(401, 4095));
      endcase
      case ($urandom_range(0, 5))
        0: gain = 8'd0;
        1: gain = 8'd255;
        2: gain = GAIN_RST;
        default: gain = 8'($urandom_range(0, 255));
      endcase
      in_tvalid <= 1'b0;
      wait_drained();
      set_regs(delay, gain);
      if ($urandom_range(0, 1) == 0) begin
        buf_left = 0;
      end
      phase_len = $urandom_range(60, 180);
      repeat (phase_len) begin
        if (buf_left == 0) begin
          start = 1'b1;
          buf_left = int'(delay) + $urandom_range(1, 2 * int'(delay) + 40);
        end else begin
          start = ($urandom_range(0, 31) == 0);
        end
        buf_left--;
        send_item(pick_sample(), start, 1'b0, typed_res);
        rand_items++;
      end
    end

    // One long buffer at a long delay, so that taps far back in the history are read
    // once the pass-through samples are done.
    in_tvalid <= 1'b0;
    wait_drained();
    set_regs(12'd300, 8'($urandom_range(128, 255)));
    for (int n = 0; n < LONG_ITEMS; n++) begin
      send_item(pick_sample(), n == 0, 1'b0, typed_res);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    // Leave room for any stray result to come out.
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
